/* design/trd_pkg.sv */
// ----------------------------------------------------------------------------
// trd_pkg: touch report decoder package
// Item types, register index codes, orientation codes and report layout.
// ----------------------------------------------------------------------------
package trd_pkg;

   // report layout
   localparam int HEADER_LEN = 3;
   localparam int RECORD_LEN = 6;
   localparam int REC_IDX_W  = 3;    // byte index inside one record

   // event codes of a finger record
   localparam logic [1:0] EV_LIFT    = 2'd1;
   localparam logic [1:0] EV_INVALID = 2'd3;

   // field masks
   localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
   localparam logic [7:0] EVENT_MASK  = 8'hC0;
   localparam logic [7:0] SLOT_MASK   = 8'hF0;

   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIENT  = 2'd0,
      CSR_X_LIMIT = 2'd1,
      CSR_Y_LIMIT = 2'd2,
      CSR_ENABLE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ORIENT_NONE          = 2'd0,
      ORIENT_SWAP          = 2'd1,
      ORIENT_SWAP_MIRROR_Y = 2'd2,
      ORIENT_SWAP_MIRROR_X = 2'd3
   } orient_type;

   typedef struct packed {
      logic [7:0] report_byte;
      logic       first_byte;
   } req_item_type;

   typedef struct packed {
      logic               has_finger;
      logic [3:0]         slot_number;
      logic               contact_active;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               frame_end;
   } rsp_item_type;

endpackage

/* design/touch_report_decoder.sv */
// ----------------------------------------------------------------------------
// touch_report_decoder: multi-touch report byte decoder
// Parses a byte stream of touch reports into finger slot events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one report byte per item; first_byte marks byte zero
//   and resyncs the parser at any time. Bytes seen before the first sync
//   are dropped.
//   rsp channel gives at most one item per request: a slot event when the
//   fourth byte of a valid finger record arrives, and/or a frame end marker
//   on the last byte of the report.
//   csr channel writes orientation_mode (0), x_limit (1), y_limit (2) and
//   enable (3); it is always ready. Write only while the block is idle.
// Each result is registered. Throughput is one byte per cycle while no result
// is stalled, set by the single output register that holds the decoded
// result. A result waiting under rsp_stall holds the request side off only
// while it is stalled; a result taken in the same cycle frees the register.
// Reset (synchronous) clears the parser to wait for sync, empties the
// output register and loads the register defaults (no rotation, limits
// 4095, enabled).
// ----------------------------------------------------------------------------
module touch_report_decoder
   import trd_pkg::*;
#(
   parameter int FINGERS      = 5,
   parameter int REPORT_BYTES = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PosW = $clog2(REPORT_BYTES);
   localparam int RecW = $clog2(FINGERS + 1);
   localparam logic [PosW:0]        LastCnt  = REPORT_BYTES[PosW:0];
   localparam logic [PosW-1:0]      HdrLen   = HEADER_LEN[PosW-1:0];
   localparam logic [REC_IDX_W-1:0] RecLast  = REC_IDX_W'(RECORD_LEN - 1);
   localparam logic [RecW-1:0]      RecCount = FINGERS[RecW-1:0];

   // configuration registers
   orient_type         orient_ff;
   logic [COORD_W-1:0] x_limit_ff;
   logic [COORD_W-1:0] y_limit_ff;
   logic               enable_ff;

   // parser state
   logic [PosW-1:0]      pos_ff, pos_in;
   logic                 frame_ff, frame_in;
   logic [REC_IDX_W-1:0] k_ff, k_in;
   logic [RecW-1:0]      rec_ff, rec_in;
   logic [23:0]          rec_bytes_ff, rec_bytes_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 accept;
   logic                 live;
   logic [PosW-1:0]      pos;
   logic [REC_IDX_W-1:0] k;
   logic [RecW-1:0]      rec;
   logic [PosW:0]        pos_next;
   logic                 in_header;
   logic                 in_record;
   logic                 complete;
   logic                 last;
   logic [7:0]           b0, b1, b2, byte_in;
   logic [COORD_W-1:0]   x, y, px, py;
   logic [1:0]           ev;
   logic                 finger;
   logic                 active;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff  <= ORIENT_NONE;
         x_limit_ff <= '1;
         y_limit_ff <= '1;
         enable_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIENT:  orient_ff  <= orient_type'(csr_data[1:0]);
            CSR_X_LIMIT: x_limit_ff <= csr_data[COORD_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr_data[COORD_W-1:0];
            CSR_ENABLE:  enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position within the report; first_byte restarts it
   always_comb begin
      byte_in   = req_item.report_byte;
      live      = req_item.first_byte || frame_ff;
      pos       = req_item.first_byte ? '0 : pos_ff;
      k         = req_item.first_byte ? '0 : k_ff;
      rec       = req_item.first_byte ? '0 : rec_ff;
      pos_next  = {1'b0, pos} + 1'b1;
      last      = pos_next >= LastCnt;
      in_header = pos < HdrLen;
      in_record = !in_header && (rec < RecCount);
      complete  = in_record && (k == REC_IDX_W'(3));
   end

   // record field extraction
   always_comb begin
      b0 = rec_bytes_ff[23:16];
      b1 = rec_bytes_ff[15:8];
      b2 = rec_bytes_ff[7:0];
      x  = {b0[3:0] & LOW_NIBBLE[3:0], b1};
      y  = {b2[3:0] & LOW_NIBBLE[3:0], byte_in};
      ev = 2'((b0 & EVENT_MASK) >> 6);
      finger = complete && (ev != EV_INVALID);
      active = ev != EV_LIFT;
   end

   // orientation, mirrored coordinates saturate at zero
   always_comb begin
      unique case (orient_ff)
         ORIENT_SWAP: begin
            px = y;
            py = x;
         end
         ORIENT_SWAP_MIRROR_Y: begin
            px = y;
            py = (y_limit_ff >= x) ? y_limit_ff - x : '0;
         end
         ORIENT_SWAP_MIRROR_X: begin
            px = (x_limit_ff >= y) ? x_limit_ff - y : '0;
            py = x;
         end
         default: begin
            px = x;
            py = y;
         end
      endcase
   end

   // parser next state
   always_comb begin
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      k_in         = k_ff;
      rec_in       = rec_ff;
      rec_bytes_in = rec_bytes_ff;
      if (accept && live) begin
         frame_in = !last;
         pos_in   = last ? '0 : pos_next[PosW-1:0];
         k_in     = k;
         rec_in   = rec;
         if (!in_header) begin
            if (k == RecLast) begin
               k_in   = '0;
               rec_in = (rec < RecCount) ? rec + 1'b1 : rec;
            end else begin
               k_in = k + 1'b1;
            end
         end
         if (in_record) begin
            unique case (k)
               REC_IDX_W'(0): rec_bytes_in[23:16] = byte_in;
               REC_IDX_W'(1): rec_bytes_in[15:8]  = byte_in;
               REC_IDX_W'(2): rec_bytes_in[7:0]   = byte_in;
               default: ;
            endcase
         end
      end
   end

   // result register
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && live && enable_ff && (finger || last)) begin
         rsp_valid_in                = 1'b1;
         rsp_item_in.has_finger      = finger;
         rsp_item_in.slot_number     = finger ? 4'((b2 & SLOT_MASK) >> 4) : 4'd0;
         rsp_item_in.contact_active  = finger && active;
         rsp_item_in.pos_x           = (finger && active) ? px : '0;
         rsp_item_in.pos_y           = (finger && active) ? py : '0;
         rsp_item_in.frame_end       = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_ff     <= 1'b0;
         k_ff         <= '0;
         rec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         k_ff         <= k_in;
         rec_ff       <= rec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_bytes_ff <= rec_bytes_in;
      rsp_item_ff  <= rsp_item_in;
   end

endmodule

/* design/trd_checker.sv */
// ----------------------------------------------------------------------------
// trd_checker: port checks for the touch report decoder
// Watches the top level ports and flags malformed results or handshakes.
// ----------------------------------------------------------------------------
module trd_checker
   import trd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_item_type          rsp_item
);

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // a full, stalled output register must hold off new bytes
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("byte accepted while result stalled");

   // every result is a finger event or a frame end, and frame end alone is empty
   a_frame_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.has_finger |-> rsp_item.frame_end
         && !rsp_item.contact_active && rsp_item.slot_number == 4'd0
         && rsp_item.pos_x == '0 && rsp_item.pos_y == '0)
      else $error("malformed frame end result");

   // a lifted finger carries no position
   a_lift_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.contact_active |-> rsp_item.pos_x == '0
         && rsp_item.pos_y == '0)
      else $error("lifted contact with position");

endmodule

bind touch_report_decoder trd_checker u_trd_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: touch report decoder testbench
// Streams touch report bytes into the decoder, predicts the slot events and
// frame end markers that each byte should produce, and checks every result
// item in order against that prediction under several register settings,
// with random idle gaps on the request side and random stalls on results.
// ----------------------------------------------------------------------------
import trd_pkg::*;

// Tracks parser state and registers, holds the slot events still to come
class slot_event_board;
   localparam int NUM_FINGERS = 5;
   localparam int NUM_BYTES   = 31;

   // register copies
   orient_type  mode;
   logic [11:0] xlim;
   logic [11:0] ylim;
   logic        en;

   // parser copies
   logic [5:0]  byte_pos;
   logic        in_frame;
   logic [23:0] rec_bytes;

   rsp_item_type expected_events[$];
   int errors;
   int taken;
   int dropped;
   int slot_events;
   int lifted;
   int frame_ends;

   function new();
      mode      = ORIENT_NONE;
      xlim      = 12'd4095;
      ylim      = 12'd4095;
      en        = 1'b1;
      byte_pos  = '0;
      in_frame  = 1'b0;
      rec_bytes = '0;
   endfunction

   function int pending();
      return expected_events.size();
   endfunction

   function void set_reg(csr_index_type idx, logic [11:0] data);
      case (idx)
         CSR_ORIENT:  mode = orient_type'(data[1:0]);
         CSR_X_LIMIT: xlim = data;
         CSR_Y_LIMIT: ylim = data;
         CSR_ENABLE:  en   = data[0];
         default: ;
      endcase
   endfunction

   // limit minus coordinate, floored at zero
   function logic [11:0] mirrored(logic [11:0] lim, logic [11:0] v);
      return (lim >= v) ? lim - v : 12'd0;
   endfunction

   // Predict the result, if any, of one accepted report byte
   function void note_byte(req_item_type it);
      int           off;
      int           rec;
      int           k;
      logic [11:0]  x;
      logic [11:0]  y;
      logic [1:0]   ev;
      logic         finger;
      logic         last;
      rsp_item_type r;

      if (it.first_byte) begin
         byte_pos = '0;
         in_frame = 1'b1;
      end
      if (!in_frame) begin
         dropped++;
         return;
      end
      taken++;
      r      = '0;
      finger = 1'b0;

      if (byte_pos >= HEADER_LEN) begin
         off = int'(byte_pos) - HEADER_LEN;
         rec = off / RECORD_LEN;
         k   = off % RECORD_LEN;
         if (rec < NUM_FINGERS) begin
            if (k < 3) begin
               rec_bytes[23 - 8*k -: 8] = it.report_byte;
            end else if (k == 3) begin
               // fourth byte completes the record
               x  = {rec_bytes[19:16], rec_bytes[15:8]};
               y  = {rec_bytes[3:0], it.report_byte};
               ev = rec_bytes[23:22];
               if (ev != EV_INVALID) begin
                  finger           = 1'b1;
                  r.has_finger     = 1'b1;
                  r.slot_number    = rec_bytes[7:4];
                  r.contact_active = (ev != EV_LIFT);
                  if (r.contact_active) begin
                     case (mode)
                        ORIENT_SWAP: begin
                           r.pos_x = y;
                           r.pos_y = x;
                        end
                        ORIENT_SWAP_MIRROR_Y: begin
                           r.pos_x = y;
                           r.pos_y = mirrored(ylim, x);
                        end
                        ORIENT_SWAP_MIRROR_X: begin
                           r.pos_x = mirrored(xlim, y);
                           r.pos_y = x;
                        end
                        default: begin
                           r.pos_x = x;
                           r.pos_y = y;
                        end
                     endcase
                  end
               end
            end
         end
      end

      // advance, closing the frame on its last byte
      last = (int'(byte_pos) + 1 >= NUM_BYTES);
      if (last) begin
         in_frame = 1'b0;
         byte_pos = '0;
      end else begin
         byte_pos = byte_pos + 6'd1;
      end

      if (en && (finger || last)) begin
         r.frame_end = last;
         expected_events.push_back(r);
         if (finger) slot_events++;
         if (finger && !r.contact_active) lifted++;
         if (last) frame_ends++;
      end
   endfunction

   function void compare_field(string fname, logic [11:0] exp_v, logic [11:0] got_v);
      if (got_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
      end
   endfunction

   // Check one accepted result against the oldest expected event
   function void check_result(rsp_item_type got);
      rsp_item_type want;
      if (expected_events.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, actual %p", $time, got);
         return;
      end
      want = expected_events.pop_front();
      compare_field("has_finger", want.has_finger, got.has_finger);
      compare_field("slot_number", want.slot_number, got.slot_number);
      compare_field("contact_active", want.contact_active, got.contact_active);
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("frame_end", want.frame_end, got.frame_end);
   endfunction
endclass

module tb_top;
   localparam int FINGERS      = 5;
   localparam int REPORT_BYTES = 31;
   localparam int PHASE_ITEMS  = 62;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   slot_event_board board;
   bit idle_on;
   bit stall_on;
   int stall_left;
   int settings;

   touch_report_decoder #(
      .FINGERS      (FINGERS),
      .REPORT_BYTES (REPORT_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_item);
   end

   // Send one report byte; may idle first when idling is on
   task automatic send_byte(input logic [7:0] b, input logic f);
      int           gap;
      req_item_type it;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.report_byte = b;
      it.first_byte  = f;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      board.note_byte(it);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Write all registers; spare upper bits of narrow registers are random
   task automatic set_regs(input orient_type m, input logic [11:0] xl,
                           input logic [11:0] yl, input logic e);
      csr_write(CSR_ORIENT, {10'($urandom), m});
      csr_write(CSR_X_LIMIT, xl);
      csr_write(CSR_Y_LIMIT, yl);
      csr_write(CSR_ENABLE, {11'($urandom), e});
      settings++;
   endtask

   // Stop sending and wait for every expected result, plus the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Coordinates lean toward the extremes and the mirror limits
   function automatic logic [11:0] pick_coord();
      logic [11:0] lim;
      lim = $urandom_range(0, 1) ? board.xlim : board.ylim;
      case ($urandom_range(0, 5))
         0: return 12'd0;
         1: return 12'd4095;
         2: return lim + 12'($urandom_range(0, 6)) - 12'd3;
         default: return 12'($urandom);
      endcase
   endfunction

   // One report with random records; sometimes cut short or preceded by junk
   task automatic send_report(input bit quiet);
      logic [7:0]  rpt [REPORT_BYTES];
      logic [11:0] x;
      logic [11:0] y;
      logic [3:0]  slot;
      int          base;
      int          len;
      if (!quiet) begin
         idle_on  = ($urandom_range(0, 2) != 0);
         stall_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      foreach (rpt[i]) rpt[i] = 8'($urandom);
      for (int r = 0; r < FINGERS; r++) begin
         base = HEADER_LEN + r * RECORD_LEN;
         x    = pick_coord();
         y    = pick_coord();
         slot = 4'($urandom);
         rpt[base]     = {2'($urandom_range(0, 3)), 2'($urandom), x[11:8]};
         rpt[base + 1] = x[7:0];
         rpt[base + 2] = {slot, y[11:8]};
         rpt[base + 3] = y[7:0];
      end
      len = REPORT_BYTES;
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, REPORT_BYTES - 1);
      for (int i = 0; i < len; i++) send_byte(rpt[i], i == 0);
   endtask

   initial begin
      int          target;
      int          waited;
      logic [11:0] mid;

      board      = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      idle_on    = 1'b0;
      stall_on   = 1'b0;
      stall_left = 0;
      settings   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: junk before sync, extreme record, lift, resync, invalid event
      idle_on  = 1'b1;
      stall_on = 1'b1;
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h0F, 1'b0);   // finger down, all coordinate bits set
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);   // record bytes four and five are skipped
      send_byte(8'h00, 1'b0);
      send_byte(8'h4A, 1'b0);   // lift-up with nonzero position
      send_byte(8'h55, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h00, 1'b1);   // resync in the middle of a record
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);   // invalid event, no result
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);   // contact at the origin
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      // random reports under a sequence of register settings
      for (int p = 0; p < 8; p++) begin
         mid = 12'($urandom_range(1000, 3000));
         case (p)
            0: set_regs(ORIENT_NONE, 12'd4095, 12'd4095, 1'b1);
            1: set_regs(ORIENT_SWAP, 12'($urandom), 12'($urandom), 1'b1);
            2: set_regs(ORIENT_SWAP_MIRROR_Y, 12'($urandom), 12'd0, 1'b1);
            3: set_regs(ORIENT_SWAP_MIRROR_X, 12'd0, 12'($urandom), 1'b1);
            4: set_regs(ORIENT_SWAP_MIRROR_Y, mid, 12'd4095, 1'b1);
            5: set_regs(ORIENT_SWAP_MIRROR_X, mid, mid, 1'b1);
            6: set_regs(orient_type'($urandom_range(0, 3)), 12'($urandom),
                        12'($urandom), 1'b0);
            default: set_regs(orient_type'($urandom_range(0, 3)), 12'($urandom),
                              12'($urandom), 1'b1);
         endcase
         // last setting runs without idling on either side
         if (p == 7) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         target = board.taken + PHASE_ITEMS;
         while (board.taken < target) send_report(p == 7);
         drain();
      end

      // final wait for stragglers
      req_valid <= 1'b0;
      waited = 0;
      while (board.pending() > 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);

      $display("Sent %0d report bytes (%0d dropped while out of sync) over %0d settings.",
               board.taken + board.dropped, board.dropped, settings);
      $display("Checked %0d slot events (%0d lifted) and %0d frame ends.",
               board.slot_events, board.lifted, board.frame_ends);
      if (board.pending() > 0)
         $display("%0t: %0d expected results never arrived", $time, board.pending());
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
design/trd_pkg.sv
design/touch_report_decoder.sv
design/trd_checker.sv
dv/tb_top.sv
